// ===== src/olm_pkg.sv =====
// ----------------------------------------------------------------------------
// olm_pkg : shared types and constants of the ordered list manager
// Sizes, operation and status codes, the decoded command record and the
// result-count helper used by the front, the queue and the back.
// ----------------------------------------------------------------------------
package olm_pkg;

    localparam int CAPACITY = 16;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W + 1 > 5) ? CNT_W + 1 : 5;

    localparam int VAL_W    = 32;
    localparam int OP_W     = 3;
    localparam int POS_W    = 5;
    localparam int ST_W     = 2;
    localparam int OCNT_W   = 5;

    // command queue, depth must be a power of two
    localparam int Q_DEPTH  = 2;
    localparam int Q_AW     = $clog2(Q_DEPTH);
    localparam int Q_CW     = $clog2(Q_DEPTH + 1);

    localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_AT   = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_HEAD = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_TAIL = 3'd4;
    localparam logic [OP_W-1:0] OP_DEL_AT   = 3'd5;
    localparam logic [OP_W-1:0] OP_LIST     = 3'd6;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

    // where an insert or delete lands
    localparam logic [1:0] W_HEAD = 2'd0;
    localparam logic [1:0] W_TAIL = 2'd1;
    localparam logic [1:0] W_AT   = 2'd2;

    typedef struct packed {
        logic                     is_ins;
        logic                     is_del;
        logic                     is_list;
        logic [1:0]               where;
        logic signed [VAL_W-1:0]  value;
        logic [POS_W-1:0]         position;
        logic                     pos_zero;
        logic [POS_W-1:0]         pos_m1;
    } t_cmd;

    // entry count as carried in a result: modulo 32
    function automatic logic [OCNT_W-1:0] cnt5(input logic [CNT_W-1:0] c);
        logic [CMP_W-1:0] t;
        t = CMP_W'(c);
        return t[OCNT_W-1:0];
    endfunction

endpackage

// ===== src/olm_if.sv =====
// ----------------------------------------------------------------------------
// olm_if : request and result channels of the ordered list manager
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface olm_in_if;
    logic              valid;
    logic              ready;
    logic [2:0]        operation;
    logic signed [31:0] value;
    logic [4:0]        position;

    modport source (output valid, operation, value, position, input ready);
    modport sink   (input valid, operation, value, position, output ready);
endinterface

interface olm_out_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] element;
    logic              element_valid;
    logic [1:0]        status;
    logic [4:0]        entry_count;
    logic              final_result;

    modport source (output valid, element, element_valid, status, entry_count,
                    final_result, input ready);
    modport sink   (input valid, element, element_valid, status, entry_count,
                    final_result, output ready);
endinterface

// ===== src/olm_front.sv =====
// ----------------------------------------------------------------------------
// olm_front : request intake and decode
// Takes one request per transfer, classifies the operation and registers the
// decoded command until the queue takes it.
// ----------------------------------------------------------------------------
module olm_front
    import olm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    olm_in_if.sink      i_cmd,
    output logic        o_push,
    output t_cmd        o_cmd,
    input  logic        i_q_full
);

    logic r_vld;
    t_cmd r_cmd;
    t_cmd n_cmd;

    assign o_push      = r_vld && !i_q_full;
    assign o_cmd       = r_cmd;
    assign i_cmd.ready = !r_vld || !i_q_full;

    always_comb begin
        n_cmd          = '0;
        n_cmd.value    = i_cmd.value;
        n_cmd.position = i_cmd.position;
        n_cmd.pos_zero = (i_cmd.position == '0);
        n_cmd.pos_m1   = i_cmd.position - POS_W'(1);
        case (i_cmd.operation)
            OP_INS_HEAD: begin
                n_cmd.is_ins = 1'b1;
                n_cmd.where  = W_HEAD;
            end
            OP_INS_TAIL: begin
                n_cmd.is_ins = 1'b1;
                n_cmd.where  = W_TAIL;
            end
            OP_INS_AT: begin
                n_cmd.is_ins = 1'b1;
                n_cmd.where  = W_AT;
            end
            OP_DEL_HEAD: begin
                n_cmd.is_del = 1'b1;
                n_cmd.where  = W_HEAD;
            end
            OP_DEL_TAIL: begin
                n_cmd.is_del = 1'b1;
                n_cmd.where  = W_TAIL;
            end
            OP_DEL_AT: begin
                n_cmd.is_del = 1'b1;
                n_cmd.where  = W_AT;
            end
            OP_LIST: begin
                n_cmd.is_list = 1'b1;
            end
            default: begin
                // unused code: no flags, answered with a plain OK
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_cmd.valid && i_cmd.ready) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ===== src/olm_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// olm_cmd_fifo : decoded command queue
// Short FIFO between decode and execution.
// ----------------------------------------------------------------------------
module olm_cmd_fifo
    import olm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_cmd        i_cmd,
    output logic        o_full,
    input  logic        i_pop,
    output t_cmd        o_cmd,
    output logic        o_valid
);

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_CW-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + Q_AW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + Q_AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + Q_CW'(1);
                2'b01:   r_cnt <= r_cnt - Q_CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

// ===== src/olm_back.sv =====
// ----------------------------------------------------------------------------
// olm_back : list execution engine
// Owns the entry memory and count; shifts entries one per cycle for
// positional insert and delete, streams entries for a listing, and holds
// the result register.
// ----------------------------------------------------------------------------
module olm_back
    import olm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    olm_out_if.source   o_res
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MOVE  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_PUT   = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;
    localparam logic [2:0] S_LIST  = 3'd5;

    // control
    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_mv;
    logic              r_out_vld, n_out_vld;
    // working
    logic [ADDR_W-1:0] r_ptr, n_ptr;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic              r_is_ins, n_is_ins;
    logic signed [VAL_W-1:0] r_val, n_val;
    // result register
    logic signed [VAL_W-1:0] r_out_elem, n_out_elem;
    logic              r_out_ev, n_out_ev;
    logic [ST_W-1:0]   r_out_st, n_out_st;
    logic [OCNT_W-1:0] r_out_cnt, n_out_cnt;
    logic              r_out_fin, n_out_fin;

    // entry memory
    logic signed [VAL_W-1:0] r_mem [CAPACITY];
    logic signed [VAL_W-1:0] r_rd_data;
    logic [ADDR_W-1:0] r_rd_addr;
    logic              we, re, move;
    logic [ADDR_W-1:0] waddr, raddr;
    logic signed [VAL_W-1:0] wdata;

    logic              slot_free;
    logic [CNT_W-1:0]  cnt_m1;
    logic [ADDR_W-1:0] last_idx;
    logic [CMP_W-1:0]  cnt_ext, pos_ext;
    logic [CNT_W-1:0]  ins_idx, del_idx;
    logic              full, empty;

    assign slot_free = !r_out_vld || o_res.ready;
    assign cnt_m1    = r_count - CNT_W'(1);
    assign last_idx  = cnt_m1[ADDR_W-1:0];
    assign cnt_ext   = CMP_W'(r_count);
    assign pos_ext   = CMP_W'(i_cmd.position);
    assign full      = (r_count >= CNT_W'(CAPACITY));
    assign empty     = (r_count == '0);

    always_comb begin
        case (i_cmd.where)
            W_HEAD:  ins_idx = '0;
            W_TAIL:  ins_idx = r_count;
            default: ins_idx = CNT_W'(i_cmd.pos_m1);
        endcase
        case (i_cmd.where)
            W_HEAD:  del_idx = '0;
            W_TAIL:  del_idx = cnt_m1;
            default: del_idx = CNT_W'(i_cmd.pos_m1);
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_ptr      = r_ptr;
        n_idx      = r_idx;
        n_is_ins   = r_is_ins;
        n_val      = r_val;
        n_out_vld  = r_out_vld && !o_res.ready;
        n_out_elem = r_out_elem;
        n_out_ev   = r_out_ev;
        n_out_st   = r_out_st;
        n_out_cnt  = r_out_cnt;
        n_out_fin  = r_out_fin;
        o_pop      = 1'b0;
        re         = 1'b0;
        raddr      = r_ptr;
        move       = 1'b0;
        // finish the shift of the entry read last cycle
        we         = r_mv;
        waddr      = r_is_ins ? r_rd_addr + ADDR_W'(1) : r_rd_addr - ADDR_W'(1);
        wdata      = r_rd_data;

        case (r_state)
            S_IDLE: begin
                if (i_q_valid && slot_free) begin
                    o_pop      = 1'b1;
                    n_out_vld  = 1'b1;
                    n_out_elem = '0;
                    n_out_ev   = 1'b0;
                    n_out_st   = ST_OK;
                    n_out_fin  = 1'b1;
                    if (i_cmd.is_ins) begin
                        if (full) begin
                            n_out_st = ST_FULL;
                        end else if (i_cmd.where == W_AT &&
                                     (i_cmd.pos_zero || pos_ext > cnt_ext + CMP_W'(1))) begin
                            n_out_st = ST_RANGE;
                        end else if (ins_idx == r_count) begin
                            // append: no entries move
                            we      = 1'b1;
                            waddr   = r_count[ADDR_W-1:0];
                            wdata   = i_cmd.value;
                            n_count = r_count + CNT_W'(1);
                        end else begin
                            n_out_vld = r_out_vld && !o_res.ready;
                            n_is_ins  = 1'b1;
                            n_val     = i_cmd.value;
                            n_idx     = ins_idx[ADDR_W-1:0];
                            n_ptr     = last_idx;
                            n_state   = S_MOVE;
                        end
                    end else if (i_cmd.is_del) begin
                        if (empty) begin
                            n_out_st = ST_EMPTY;
                        end else if (i_cmd.where == W_AT &&
                                     (i_cmd.pos_zero || pos_ext > cnt_ext)) begin
                            n_out_st = ST_RANGE;
                        end else if (del_idx == cnt_m1) begin
                            // last entry goes: nothing to close up
                            n_count = cnt_m1;
                        end else begin
                            n_out_vld = r_out_vld && !o_res.ready;
                            n_is_ins  = 1'b0;
                            n_ptr     = del_idx[ADDR_W-1:0] + ADDR_W'(1);
                            n_state   = S_MOVE;
                        end
                    end else if (i_cmd.is_list) begin
                        if (empty) begin
                            n_out_st = ST_EMPTY;
                        end else begin
                            n_out_vld = r_out_vld && !o_res.ready;
                            re        = 1'b1;
                            raddr     = '0;
                            n_ptr     = '0;
                            n_state   = S_LIST;
                        end
                    end
                    n_out_cnt = cnt5(n_count);
                end
            end
            S_MOVE: begin
                re    = 1'b1;
                raddr = r_ptr;
                move  = 1'b1;
                if (r_is_ins) begin
                    if (r_ptr == r_idx) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_ptr = r_ptr - ADDR_W'(1);
                    end
                end else begin
                    if (r_ptr == last_idx) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_ptr = r_ptr + ADDR_W'(1);
                    end
                end
            end
            S_DRAIN: begin
                if (r_is_ins) begin
                    n_state = S_PUT;
                end else begin
                    n_count = cnt_m1;
                    n_state = S_RESP;
                end
            end
            S_PUT: begin
                we      = 1'b1;
                waddr   = r_idx;
                wdata   = r_val;
                n_count = r_count + CNT_W'(1);
                n_state = S_RESP;
            end
            S_RESP: begin
                if (slot_free) begin
                    n_out_vld  = 1'b1;
                    n_out_elem = '0;
                    n_out_ev   = 1'b0;
                    n_out_st   = ST_OK;
                    n_out_cnt  = cnt5(r_count);
                    n_out_fin  = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_LIST: begin
                if (slot_free) begin
                    n_out_vld  = 1'b1;
                    n_out_elem = r_rd_data;
                    n_out_ev   = 1'b1;
                    n_out_st   = ST_OK;
                    n_out_cnt  = cnt5(r_count);
                    n_out_fin  = (r_ptr == last_idx);
                    if (r_ptr == last_idx) begin
                        n_state = S_IDLE;
                    end else begin
                        re    = 1'b1;
                        raddr = r_ptr + ADDR_W'(1);
                        n_ptr = r_ptr + ADDR_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_mv      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_mv      <= move;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr      <= n_ptr;
        r_idx      <= n_idx;
        r_is_ins   <= n_is_ins;
        r_val      <= n_val;
        r_out_elem <= n_out_elem;
        r_out_ev   <= n_out_ev;
        r_out_st   <= n_out_st;
        r_out_cnt  <= n_out_cnt;
        r_out_fin  <= n_out_fin;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (re) begin
            r_rd_data <= r_mem[raddr];
            r_rd_addr <= raddr;
        end
    end

    assign o_res.valid         = r_out_vld;
    assign o_res.element       = r_out_elem;
    assign o_res.element_valid = r_out_ev;
    assign o_res.status        = r_out_st;
    assign o_res.entry_count   = r_out_cnt;
    assign o_res.final_result  = r_out_fin;

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_move_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mv |-> ($past(r_state) == S_MOVE))
        else $error("shift write-back without a shift read");

    a_list_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) |-> (r_count != '0))
        else $error("listing an empty list");

    a_move_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOVE) |-> (CNT_W'(r_ptr) < r_count))
        else $error("shift pointer past the last entry");

    a_elem_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_ev) |-> (r_out_st == ST_OK))
        else $error("listed element with non-OK status");

endmodule

// ===== src/ordered_list_manager_core.sv =====
// ----------------------------------------------------------------------------
// ordered_list_manager_core : ordered list of signed 32-bit values
// Insert/delete at head, tail or position, and list-all, over a compacted
// entry memory of CAPACITY words.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                       transfer when
//  i_cmd     in   operation, value, position                    valid & ready
//  o_res     out  element, element_valid, status, entry_count,  valid & ready
//                 final_result
//
//  Flow: a request passes the decode register and the command queue on
//  its way to the engine. Status-only requests (errors, appends, deletes
//  of the last entry, unused codes) are answered the cycle after they
//  leave the queue. A shifting insert steps through the move, drain, put
//  and response states and a shifting delete through move, drain and
//  response; the entry memory has a single read and a single write port.
//  A listing gives one element per cycle when the result side keeps taking.
//  Reset clears the count and control only; entry memory needs no clearing.
//  Either side may stall: the decode register and command queue keep
//  accepting until the queue is full while the result register waits.
// ----------------------------------------------------------------------------
module ordered_list_manager_core
    import olm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    olm_in_if.sink   i_cmd,
    olm_out_if.source o_res
);

    // decoded command toward the queue
    logic push;
    t_cmd front_cmd;
    logic q_full;

    // queue head toward the engine
    logic q_valid;
    logic q_pop;
    t_cmd q_cmd;

    olm_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .o_push   (push),
        .o_cmd    (front_cmd),
        .i_q_full (q_full)
    );

    olm_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_valid (q_valid)
    );

    // execution: owns the entries, the count and the result register
    olm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (q_cmd),
        .o_pop     (q_pop),
        .o_res     (o_res)
    );

endmodule
